[rtl/bottom_up_merge_sorter_top_macros.svh]
// Assertion macros used by the sorter top module.
`ifndef BOTTOM_UP_MERGE_SORTER_TOP_MACROS_SVH
`define BOTTOM_UP_MERGE_SORTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that cond holds at every clock edge out of reset.
`define BUMS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that cons holds in the same cycle as ante.
`define BUMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define BUMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BUMS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define BUMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BUMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/bums_pkg.sv]
// Shared types and defaults for the sorter.
package bums_pkg;

    localparam int MAX_LEN_DEF   = 64;
    localparam int KEY_WIDTH_DEF = 64;
    localparam int KEY_OUT_W     = 64;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;    // insert the new key in sorted position
        logic shift;  // move every key one cell toward the head
    } t_cell_ctl;

endpackage

[rtl/bums_cell.sv]
// One compare-and-insert cell of the sorting chain.
module bums_cell #(
    parameter int KEY_WIDTH = bums_pkg::KEY_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bums_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_WIDTH-1:0]  i_new_key,
    input  logic                  i_left_valid,
    input  logic [KEY_WIDTH-1:0]  i_left_key,
    input  logic                  i_left_gt,
    input  logic                  i_right_valid,
    input  logic [KEY_WIDTH-1:0]  i_right_key,
    output logic                  o_valid,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic                  o_gt
);
    import bums_pkg::*;

    logic                 r_valid;
    logic                 n_valid;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;

    // An empty cell counts as holding a key above everything.
    assign o_gt    = !r_valid || ($signed(r_key) > $signed(i_new_key));
    assign o_valid = r_valid;
    assign o_key   = r_key;

    always_comb begin
        priority if (i_ctl.shift) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
        end else if (i_ctl.ins && o_gt) begin
            // take the left neighbor's key if it also moves, else the new key
            if (i_left_gt) begin
                n_valid = i_left_valid;
                n_key   = i_left_key;
            end else begin
                n_valid = 1'b1;
                n_key   = i_new_key;
            end
        end else begin
            // hold
            n_valid = r_valid;
            n_key   = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

[rtl/bottom_up_merge_sorter_top.sv]
// Key sorter: a chain of MAX_LEN insertion cells keeps the keys of a run in ascending
// order as they arrive, one key per cycle, and then streams them out from the head of
// the chain one per cycle while i_out_ready is high; each result leaves as soon as the
// chain has shifted it to the head cell. The input is not ready during emission.
// Keys beyond MAX_LEN in one run are dropped; the final flag still ends the run.
// Keys are taken from the low KEY_WIDTH bits of key_in, compared as signed values and
// returned sign-extended to 64 bits.
module bottom_up_merge_sorter_top #(
    parameter int MAX_LEN   = bums_pkg::MAX_LEN_DEF,
    parameter int KEY_WIDTH = bums_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bums_pkg::KEY_OUT_W-1:0] i_key_in,
    input  logic                          i_final_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bums_pkg::KEY_OUT_W-1:0] o_key_out,
    output logic                          o_final_out
);
    import bums_pkg::*;

`include "bottom_up_merge_sorter_top_macros.svh"

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    localparam logic PH_LOAD = 1'b0;
    localparam logic PH_EMIT = 1'b1;

    logic             r_phase;
    logic             n_phase;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    t_cell_ctl            w_ctl;
    logic                 w_in_acc;
    logic [KEY_WIDTH-1:0] w_new_key;
    logic [MAX_LEN-1:0]   w_valid;
    logic [MAX_LEN-1:0]   w_gt;
    logic [KEY_WIDTH-1:0] w_key [MAX_LEN];

    assign o_in_ready  = (r_phase == PH_LOAD);
    assign o_out_valid = (r_phase == PH_EMIT);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_new_key   = i_key_in[KEY_WIDTH-1:0];

    assign w_ctl.ins   = w_in_acc && (r_count < CNT_W'(MAX_LEN));
    assign w_ctl.shift = o_out_valid && i_out_ready;

    assign o_key_out   = KEY_OUT_W'($signed(w_key[0]));
    assign o_final_out = (r_count == CNT_W'(1));

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        unique case (r_phase)
            PH_LOAD: begin
                if (w_ctl.ins) begin
                    n_count = r_count + CNT_W'(1);
                end
                if (w_in_acc && i_final_in) begin
                    n_phase = PH_EMIT;
                end
            end
            PH_EMIT: begin
                if (w_ctl.shift) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_phase = PH_LOAD;
                    end
                end
            end
            default: begin
                n_phase = PH_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LOAD;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        logic                 w_lv;
        logic [KEY_WIDTH-1:0] w_lk;
        logic                 w_lg;
        logic                 w_rv;
        logic [KEY_WIDTH-1:0] w_rk;

        if (g == 0) begin : g_head
            assign w_lv = 1'b0;
            assign w_lk = '0;
            assign w_lg = 1'b0;
        end else begin : g_body
            assign w_lv = w_valid[g-1];
            assign w_lk = w_key[g-1];
            assign w_lg = w_gt[g-1];
        end

        if (g == MAX_LEN - 1) begin : g_tail
            assign w_rv = 1'b0;
            assign w_rk = '0;
        end else begin : g_next
            assign w_rv = w_valid[g+1];
            assign w_rk = w_key[g+1];
        end

        bums_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_key     (w_new_key),
            .i_left_valid  (w_lv),
            .i_left_key    (w_lk),
            .i_left_gt     (w_lg),
            .i_right_valid (w_rv),
            .i_right_key   (w_rk),
            .o_valid       (w_valid[g]),
            .o_key         (w_key[g]),
            .o_gt          (w_gt[g])
        );
    end

    `BUMS_ASSERT_ALWAYS(a_count_matches_cells, i_clk, i_rst_n,
        $countones(w_valid) == int'(r_count), "occupied cells disagree with key count")
    `BUMS_ASSERT_IMPL(a_emit_nonempty, i_clk, i_rst_n,
        o_out_valid, r_count != '0, "emitting with an empty chain")
    `BUMS_ASSERT_IMPL(a_head_sorted, i_clk, i_rst_n,
        w_valid[1], $signed(w_key[0]) <= $signed(w_key[1]), "head of chain out of order")
    `BUMS_ASSERT_NEXT(a_last_frees_input, i_clk, i_rst_n,
        o_out_valid && i_out_ready && o_final_out, o_in_ready && r_count == '0,
        "run not closed after last request")

endmodule
